>>> rtl/plasma_pixel_generator_unit_assert.svh
// Assertion macros for the plasma pixel generator checker.
`ifndef PLASMA_PIXEL_GENERATOR_UNIT_ASSERT_SVH
`define PLASMA_PIXEL_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, skipped while rst is high
`define PPG_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plasma pixel generator check failed");

// next-cycle implication, skipped while rst is high
`define PPG_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plasma pixel generator check failed");

// condition that must hold in the cycle after reset was high
`define PPG_ASSERT_AFTER_RST(name, cons) \
  name: assert property (@(posedge clk) $past(rst) |-> (cons)) \
    else $error("plasma pixel generator check failed");

`endif

>>> rtl/ppg_pkg.sv
// Package: constants and 8-bit math helpers of the plasma pixel generator.
package ppg_pkg;

  localparam int LED_COUNT = 128;

  localparam int BEAT_SCALE = 280;
  localparam logic [23:0] BEAT_K1 = 24'(2 * BEAT_SCALE);
  localparam logic [23:0] BEAT_K2 = 24'(3 * BEAT_SCALE);
  localparam logic [23:0] BEAT_K3 = 24'(7 * BEAT_SCALE);

  localparam logic [7:0] PHASE_LOW   = 8'd192;
  localparam logic [7:0] PHASE_SPAN  = 8'd128;
  localparam logic [7:0] BRIGHT_SPAN = 8'd128;
  localparam logic [7:0] COS_SHIFT   = 8'd64;
  localparam logic [7:0] WHEEL_SEG1  = 8'd85;
  localparam logic [7:0] WHEEL_SEG2  = 8'd170;
  localparam logic [7:0] DIM_FLOOR   = 8'd2;

  localparam logic [6:0] SINE_SEG [8] = '{7'd0, 7'd49, 7'd49, 7'd41,
                                          7'd90, 7'd27, 7'd117, 7'd10};

  typedef logic [7:0] u8_t;

  function automatic u8_t scale8(input u8_t v, input u8_t s);
    logic [15:0] prod;
    prod = {8'd0, v} * ({8'd0, s} + 16'd1);
    return prod[15:8];
  endfunction

  function automatic u8_t sine8(input u8_t theta);
    u8_t         off_full;
    logic [5:0]  off;
    logic [4:0]  sec;
    logic [1:0]  seg;
    logic [6:0]  slope;
    logic [6:0]  base;
    logic [10:0] prod;
    u8_t         y;
    off_full = theta[6] ? ~theta : theta;
    off      = off_full[5:0];
    sec      = {1'b0, off[3:0]} + {4'd0, theta[6]};
    seg      = off[5:4];
    slope    = SINE_SEG[{seg, 1'b1}];
    base     = SINE_SEG[{seg, 1'b0}];
    prod     = {4'd0, slope} * {6'd0, sec};
    y        = {1'b0, prod[10:4]} + {1'b0, base};
    return theta[7] ? (8'd128 - y) : (8'd128 + y);
  endfunction

endpackage

>>> rtl/plasma_pixel_generator_unit.sv
// Top level: six-stage pipeline computing one plasma pixel color per beat.
// One pixel enters per clock unless the output stalls; its color leaves
// after the six registered stages (beat phase multiply, sine and
// oscillator scaling, wave arguments, two easing multiplies, color wheel).
// There is no state between pixels. A stall on the output freezes every
// stage at once, so s_tready is low only while a finished color waits.
module plasma_pixel_generator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // time_ms[31:0], pixel_index[38:32], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

  logic advance;
  logic v1, v2, v3, v4, v5, v6;

  // stage 1: beat phases
  logic [23:0] prod1, prod2, prod3;
  ppg_pkg::u8_t beat1, beat2, beat3;
  logic [6:0] k1;

  // stage 2: oscillators
  ppg_pkg::u8_t ph1, ph2, bthr2;
  logic [6:0] k2;

  // stage 3: wave inputs
  ppg_pkg::u8_t tri_arg, cos_arg, tri_fold;
  ppg_pkg::u8_t ease_i3, cos3, bthr3;

  // stage 4: square
  ppg_pkg::u8_t ii4, ease_i4, cos4, bthr4;

  // stage 5: cube and index
  ppg_pkg::u8_t iii;
  logic [9:0] cubic_raw;
  ppg_pkg::u8_t cubic, idx5, bthr5;

  // stage 6: wheel and threshold
  ppg_pkg::u8_t bright, pos, seg_off, seg_x3;
  ppg_pkg::u8_t red_next, green_raw, blue_raw, green_next, blue_next;
  ppg_pkg::u8_t red, green, blue;

  assign advance  = !v6 || m_tready;
  assign s_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (advance) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // only the low 24 time bits reach phase bits [23:16]
  assign prod1 = s_tdata[23:0] * ppg_pkg::BEAT_K1;
  assign prod2 = s_tdata[23:0] * ppg_pkg::BEAT_K2;
  assign prod3 = s_tdata[23:0] * ppg_pkg::BEAT_K3;

  always_ff @(posedge clk) begin
    if (advance) begin
      beat1 <= prod1[23:16];
      beat2 <= prod2[23:16];
      beat3 <= prod3[23:16];
      k1    <= s_tdata[38:32];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ph1   <= ppg_pkg::PHASE_LOW +
               ppg_pkg::scale8(ppg_pkg::sine8(beat1), ppg_pkg::PHASE_SPAN);
      ph2   <= ppg_pkg::PHASE_LOW +
               ppg_pkg::scale8(ppg_pkg::sine8(beat2), ppg_pkg::PHASE_SPAN);
      bthr2 <= ppg_pkg::scale8(ppg_pkg::sine8(beat3), ppg_pkg::BRIGHT_SPAN);
      k2    <= k1;
    end
  end

  assign tri_arg  = {k2, 1'b0} + ph1;
  assign cos_arg  = {1'b0, k2} + ph2 + ppg_pkg::COS_SHIFT;
  assign tri_fold = tri_arg[7] ? ~tri_arg : tri_arg;

  always_ff @(posedge clk) begin
    if (advance) begin
      ease_i3 <= {tri_fold[6:0], 1'b0};
      cos3    <= ppg_pkg::sine8(cos_arg);
      bthr3   <= bthr2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ii4     <= ppg_pkg::scale8(ease_i3, ease_i3);
      ease_i4 <= ease_i3;
      cos4    <= cos3;
      bthr4   <= bthr3;
    end
  end

  assign iii       = ppg_pkg::scale8(ii4, ease_i4);
  assign cubic_raw = {1'b0, ii4, 1'b0} + {2'd0, ii4} - {1'b0, iii, 1'b0};
  assign cubic     = cubic_raw[8] ? 8'hFF : cubic_raw[7:0];

  always_ff @(posedge clk) begin
    if (advance) begin
      idx5  <= {1'b0, cubic[7:1]} + {1'b0, cos4[7:1]};
      bthr5 <= bthr4;
    end
  end

  assign bright = (idx5 > bthr5) ? (idx5 - bthr5) : 8'd0;
  assign pos    = ~idx5;

  always_comb begin
    priority if (pos < ppg_pkg::WHEEL_SEG1) begin
      seg_off = pos;
    end else if (pos < ppg_pkg::WHEEL_SEG2) begin
      seg_off = pos - ppg_pkg::WHEEL_SEG1;
    end else begin
      seg_off = pos - ppg_pkg::WHEEL_SEG2;
    end
  end

  assign seg_x3 = {seg_off[6:0], 1'b0} + seg_off;

  always_comb begin
    priority if (pos < ppg_pkg::WHEEL_SEG1) begin
      red_next  = 8'hFF - seg_x3;
      green_raw = 8'd0;
      blue_raw  = seg_x3;
    end else if (pos < ppg_pkg::WHEEL_SEG2) begin
      red_next  = 8'd0;
      green_raw = seg_x3;
      blue_raw  = 8'hFF - seg_x3;
    end else begin
      red_next  = seg_x3;
      green_raw = 8'hFF - seg_x3;
      blue_raw  = 8'd0;
    end
  end

  assign green_next = (green_raw > bright) ? (green_raw - bright) : ppg_pkg::DIM_FLOOR;
  assign blue_next  = (blue_raw > bright) ? (blue_raw - bright) : ppg_pkg::DIM_FLOOR;

  always_ff @(posedge clk) begin
    if (advance) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign m_tvalid = v6;
  assign m_tdata  = {blue, green, red};

endmodule

>>> rtl/ppg_checker.sv
// Checker: port-level assertions for the plasma pixel generator, bound to the top level.
`include "plasma_pixel_generator_unit_assert.svh"

module ppg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [39:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  logic in_beat;
  assign in_beat = s_tvalid && s_tready && (s_tdata[39] == 1'b0 || s_tdata[39] == 1'b1);

  // a held output beat keeps its color
  `PPG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // input is only held back by a waiting color
  `PPG_ASSERT_NOW(a_ready_when_empty, !m_tvalid || m_tready, s_tready)
  // dimmed green and blue never reach zero
  `PPG_ASSERT_NOW(a_gb_nonzero, m_tvalid, m_tdata[15:8] != 8'd0 && m_tdata[23:16] != 8'd0)
  // no output beat right after reset, unless an input beat was taken while rst was high
  `PPG_ASSERT_AFTER_RST(a_empty_after_rst, !m_tvalid || $past(in_beat))

endmodule

bind plasma_pixel_generator_unit ppg_checker u_ppg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
